// ----- rtl/core/mwrfb_pkg.sv -----
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
`timescale 1ns / 1ps

package mwrfb_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_SET  = 2'd1,
    ACT_STOP = 2'd2,
    ACT_RUN  = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS    = 2'd0,
    CFG_FREQUENCY_LIMIT   = 2'd1,
    CFG_CONTROL_REGISTER  = 2'd2,
    CFG_SETPOINT_REGISTER = 2'd3
  } cfg_index_t;

  // Byte positions inside one 8-byte frame.
  localparam logic [2:0] BYTE_DEV     = 3'd0;
  localparam logic [2:0] BYTE_FUNC    = 3'd1;
  localparam logic [2:0] BYTE_REG_HI  = 3'd2;
  localparam logic [2:0] BYTE_REG_LO  = 3'd3;
  localparam logic [2:0] BYTE_VAL_HI  = 3'd4;
  localparam logic [2:0] BYTE_VAL_LO  = 3'd5;
  localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
  localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CW_INIT           = 16'h0006;
  localparam logic [15:0] CW_STOP           = 16'h0007;
  localparam logic [15:0] CW_RUN            = 16'h000F;

  localparam logic [7:0]  RST_DEVICE_ADDRESS    = 8'h0B;
  localparam logic [15:0] RST_FREQUENCY_LIMIT   = 16'd500;
  localparam logic [15:0] RST_CONTROL_REGISTER  = 16'h2135;
  localparam logic [15:0] RST_SETPOINT_REGISTER = 16'h2136;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] frequency_limit;
    logic [15:0] control_register;
    logic [15:0] setpoint_register;
  } cfg_regs_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] frequency;
  } cmd_t;

  // One byte of CRC-16/MODBUS, LSB first with the reflected polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mwrfb_frame_seq.sv -----
// Frame sequencer: walks one or two frames byte by byte and holds the output register.
`timescale 1ns / 1ps

module mwrfb_frame_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwrfb_pkg::cfg_regs_t  cfg,
  input  logic                  cmd_valid,
  input  mwrfb_pkg::cmd_t       cmd,
  output logic                  cmd_take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);

  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] reg_addr_r, reg_addr_nxt;
  logic [15:0] value_r, value_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic        more_r, more_nxt;
  logic        final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        push;
  logic        frame_end;
  logic [15:0] crc_cur;
  logic [7:0]  cur_byte;
  logic [15:0] clamped;

  assign push      = active_r && (!out_valid_r || out_tready);
  assign frame_end = push && (idx_r == mwrfb_pkg::BYTE_CRC_HI);
  assign cmd_take  = cmd_valid && (!active_r || (frame_end && !more_r));
  assign crc_cur   = (idx_r == mwrfb_pkg::BYTE_DEV) ? mwrfb_pkg::CRC_INIT : crc_r;
  assign clamped   = (cmd.frequency > cfg.frequency_limit) ? cfg.frequency_limit
                                                            : cmd.frequency;

  always_comb begin
    case (idx_r)
      mwrfb_pkg::BYTE_DEV:    cur_byte = cfg.device_address;
      mwrfb_pkg::BYTE_FUNC:   cur_byte = mwrfb_pkg::FUNC_WRITE_SINGLE;
      mwrfb_pkg::BYTE_REG_HI: cur_byte = reg_addr_r[15:8];
      mwrfb_pkg::BYTE_REG_LO: cur_byte = reg_addr_r[7:0];
      mwrfb_pkg::BYTE_VAL_HI: cur_byte = value_r[15:8];
      mwrfb_pkg::BYTE_VAL_LO: cur_byte = value_r[7:0];
      mwrfb_pkg::BYTE_CRC_LO: cur_byte = crc_r[7:0];
      default:                cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    reg_addr_nxt  = reg_addr_r;
    value_nxt     = value_r;
    freq_nxt      = freq_r;
    more_nxt      = more_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (push) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = final_r && (idx_r == mwrfb_pkg::BYTE_CRC_HI);
      idx_nxt       = idx_r + 3'd1;
      // The CRC only covers the six header and value bytes.
      if (idx_r < mwrfb_pkg::BYTE_CRC_LO) begin
        crc_nxt = mwrfb_pkg::crc_byte(crc_cur, cur_byte);
      end
      if (frame_end) begin
        if (more_r) begin
          // Init: the setpoint frame follows the control-word frame.
          reg_addr_nxt = cfg.setpoint_register;
          value_nxt    = freq_r;
          more_nxt     = 1'b0;
          final_nxt    = 1'b1;
        end else begin
          active_nxt = 1'b0;
        end
      end
    end

    if (cmd_take) begin
      active_nxt = 1'b1;
      idx_nxt    = mwrfb_pkg::BYTE_DEV;
      freq_nxt   = clamped;
      unique case (cmd.action)
        mwrfb_pkg::ACT_INIT: begin
          reg_addr_nxt = cfg.control_register;
          value_nxt    = mwrfb_pkg::CW_INIT;
          more_nxt     = 1'b1;
          final_nxt    = 1'b0;
        end
        mwrfb_pkg::ACT_SET: begin
          reg_addr_nxt = cfg.setpoint_register;
          value_nxt    = clamped;
          more_nxt     = 1'b0;
          final_nxt    = 1'b1;
        end
        mwrfb_pkg::ACT_STOP: begin
          reg_addr_nxt = cfg.control_register;
          value_nxt    = mwrfb_pkg::CW_STOP;
          more_nxt     = 1'b0;
          final_nxt    = 1'b1;
        end
        default: begin
          reg_addr_nxt = cfg.control_register;
          value_nxt    = mwrfb_pkg::CW_RUN;
          more_nxt     = 1'b0;
          final_nxt    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= mwrfb_pkg::BYTE_DEV;
      more_r      <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      more_r      <= more_nxt;
      final_r     <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    reg_addr_r <= reg_addr_nxt;
    value_r    <= value_nxt;
    freq_r     <= freq_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/modbus_write_register_frame_builder.sv -----
// Top level of the Modbus RTU function-6 frame builder with its configuration registers.
`timescale 1ns / 1ps

// Channel  | Direction | Transfer carries
// ---------+-----------+-----------------------------------------------------------
// in_      | slave     | one command: action in tuser, frequency in tdata
// out_     | master    | one frame byte in tdata, tlast on the final byte of a command
// cfg_     | slave     | register index and write data, always ready
//
// Each command produces one 8-byte frame (init produces two, 16 bytes) at one byte
// per cycle while the output accepts, so a command holds the byte sequencer for its
// frames plus any stall on the output side. The CRC is built one byte per cycle as the
// header bytes leave, so the frame length sets the rate. A one-entry input register
// takes the next command while a frame is still going out. Reset (synchronous,
// active low) empties both registers and restores the configuration defaults.

module modbus_write_register_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  // Command input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] frequency
  input  logic [1:0]  in_tuser,   // [1:0] action
  // Frame byte output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mwrfb_pkg::cfg_regs_t cfg_r, cfg_nxt;

  // Input holding register: one command waiting for the sequencer.
  logic            pend_valid_r, pend_valid_nxt;
  mwrfb_pkg::cmd_t pend_r, pend_nxt;
  logic            cmd_take;

  assign cfg_ready = 1'b1;
  assign in_tready = !pend_valid_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (mwrfb_pkg::cfg_index_t'(cfg_index))
        mwrfb_pkg::CFG_DEVICE_ADDRESS:    cfg_nxt.device_address    = cfg_data[7:0];
        mwrfb_pkg::CFG_FREQUENCY_LIMIT:   cfg_nxt.frequency_limit   = cfg_data;
        mwrfb_pkg::CFG_CONTROL_REGISTER:  cfg_nxt.control_register  = cfg_data;
        default:                          cfg_nxt.setpoint_register = cfg_data;
      endcase
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (cmd_take) begin
      pend_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      pend_valid_nxt     = 1'b1;
      pend_nxt.action    = mwrfb_pkg::action_t'(in_tuser);
      pend_nxt.frequency = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= mwrfb_pkg::RST_DEVICE_ADDRESS;
      cfg_r.frequency_limit   <= mwrfb_pkg::RST_FREQUENCY_LIMIT;
      cfg_r.control_register  <= mwrfb_pkg::RST_CONTROL_REGISTER;
      cfg_r.setpoint_register <= mwrfb_pkg::RST_SETPOINT_REGISTER;
      pend_valid_r            <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  mwrfb_frame_seq u_frame_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_valid  (pend_valid_r),
    .cmd        (pend_r),
    .cmd_take   (cmd_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
